// File: hdl/contour_box_plate_classifier_macros.svh
// assertion macros shared by the contour box plate classifier modules
`ifndef CONTOUR_BOX_PLATE_CLASSIFIER_MACROS_SVH
`define CONTOUR_BOX_PLATE_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CBPC_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CBPC_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hdl/cbpc_pkg.sv
// shared types and constants of the contour box plate classifier
package cbpc_pkg;

  localparam int unsigned CoordBits     = 12;
  localparam int unsigned FrameBits     = 25;
  localparam int unsigned RatioBits     = 10;
  localparam int unsigned CfgIndexBits  = 3;
  localparam int unsigned CfgDataBits   = FrameBits;
  localparam int unsigned AreaBits      = 2 * CoordBits;
  localparam int unsigned LoFactorBits  = RatioBits + 1;
  localparam int unsigned LoProdBits    = AreaBits + LoFactorBits;
  localparam int unsigned HiProdBits    = AreaBits + RatioBits;
  localparam int unsigned AspectBits    = CoordBits + 4;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrBits  = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits  = $clog2(QueueDepth + 1);

  localparam logic [AspectBits-1:0] AspectWidthMul  = AspectBits'(5);
  localparam logic [AspectBits-1:0] AspectHeightMul = AspectBits'(13);
  localparam logic [AspectBits-1:0] AspectMaxRatio  = AspectBits'(7);

  localparam logic [FrameBits-1:0] FrameAreaReset     = FrameBits'(307200);
  localparam logic [RatioBits-1:0] AreaRatioLowReset  = RatioBits'(30);
  localparam logic [RatioBits-1:0] AreaRatioHighReset = RatioBits'(270);
  localparam logic [CoordBits-1:0] MinBoxWidthReset   = CoordBits'(80);
  localparam logic [CoordBits-1:0] MaxBoxWidthReset   = CoordBits'(250);
  localparam logic [CoordBits-1:0] MinBoxHeightReset  = CoordBits'(25);
  localparam logic [CoordBits-1:0] MaxBoxHeightReset  = CoordBits'(150);

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_FRAME_AREA      = 3'd0,
    CFG_AREA_RATIO_LOW  = 3'd1,
    CFG_AREA_RATIO_HIGH = 3'd2,
    CFG_MIN_BOX_WIDTH   = 3'd3,
    CFG_MAX_BOX_WIDTH   = 3'd4,
    CFG_MIN_BOX_HEIGHT  = 3'd5,
    CFG_MAX_BOX_HEIGHT  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_REJECT    = 2'd0,
    VERDICT_AREA_OK   = 2'd1,
    VERDICT_ASPECT_OK = 2'd2,
    VERDICT_ALL_OK    = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_AREA,
    BK_JUDGE
  } back_state_e;

  typedef struct packed {
    logic [FrameBits-1:0] frame_area;
    logic [RatioBits-1:0] area_ratio_low;
    logic [RatioBits-1:0] area_ratio_high;
    logic [CoordBits-1:0] min_box_width;
    logic [CoordBits-1:0] max_box_width;
    logic [CoordBits-1:0] min_box_height;
    logic [CoordBits-1:0] max_box_height;
  } cfg_t;

  typedef struct packed {
    logic [CoordBits-1:0] left;
    logic [CoordBits-1:0] top;
    logic [CoordBits-1:0] width;
    logic [CoordBits-1:0] height;
  } box_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hdl/cbpc_front.sv
// front end: tracks the bounding box of the current contour and queues it
module cbpc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cbpc_pkg::CoordBits-1:0] point_x_i,
  input  logic [cbpc_pkg::CoordBits-1:0] point_y_i,
  input  logic                          last_point_i,
  input  cbpc_pkg::q_status_t           q_status_i,
  output logic                          push_o,
  output cbpc_pkg::box_t                box_o
);
  import cbpc_pkg::*;

  logic [CoordBits-1:0] x_low_q, x_low_d, x_high_q, x_high_d;
  logic [CoordBits-1:0] y_low_q, y_low_d, y_high_q, y_high_d;
  logic                 first_q, first_d;
  logic                 accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  always_comb begin
    if (first_q) begin
      x_low_d  = point_x_i;
      x_high_d = point_x_i;
      y_low_d  = point_y_i;
      y_high_d = point_y_i;
    end else begin
      x_low_d  = (point_x_i < x_low_q)  ? point_x_i : x_low_q;
      x_high_d = (point_x_i > x_high_q) ? point_x_i : x_high_q;
      y_low_d  = (point_y_i < y_low_q)  ? point_y_i : y_low_q;
      y_high_d = (point_y_i > y_high_q) ? point_y_i : y_high_q;
    end
    first_d = accept ? last_point_i : first_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= '0;
      x_high_q <= '0;
      y_low_q  <= '0;
      y_high_q <= '0;
      first_q  <= 1'b1;
    end else begin
      first_q <= first_d;
      if (accept) begin
        x_low_q  <= x_low_d;
        x_high_q <= x_high_d;
        y_low_q  <= y_low_d;
        y_high_q <= y_high_d;
      end
    end
  end

  assign push_o       = accept && last_point_i;
  assign box_o.left   = x_low_d;
  assign box_o.top    = y_low_d;
  assign box_o.width  = x_high_d - x_low_d;
  assign box_o.height = y_high_d - y_low_d;

endmodule

// File: hdl/cbpc_queue.sv
// short box queue between the point tracker and the judge unit
`include "contour_box_plate_classifier_macros.svh"
module cbpc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cbpc_pkg::box_t      data_i,
  input  logic                pop_i,
  output cbpc_pkg::box_t      data_o,
  output cbpc_pkg::q_status_t status_o
);
  import cbpc_pkg::*;

  box_t                    entries_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntBits-1:0] count_q, count_d;
  logic                    do_push, do_pop;

  assign status_o.full  = (count_q == QueueCntBits'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign data_o         = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  `CBPC_ASSERT_IMP(a_no_pop_empty, status_o.empty, !pop_i, "pop from empty box queue")
  `CBPC_ASSERT_IMP(a_no_push_full, status_o.full, !push_i, "push into full box queue")
  `CBPC_ASSERT_NXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + QueueCntBits'(1),
                   "queue count did not follow a push")

endmodule

// File: hdl/cbpc_back.sv
// back end: area, aspect and size tests on queued boxes, registered result
`include "contour_box_plate_classifier_macros.svh"
module cbpc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cbpc_pkg::cfg_t                 cfg_i,
  input  cbpc_pkg::q_status_t            q_status_i,
  input  cbpc_pkg::box_t                 q_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cbpc_pkg::CoordBits-1:0] box_left_o,
  output logic [cbpc_pkg::CoordBits-1:0] box_top_o,
  output logic [cbpc_pkg::CoordBits-1:0] box_width_o,
  output logic [cbpc_pkg::CoordBits-1:0] box_height_o,
  output logic [1:0]                     verdict_o
);
  import cbpc_pkg::*;

  back_state_e           state_q, state_d;
  box_t                  box_q;
  box_t                  out_box_q;
  verdict_e              verdict_q, verdict_d;
  logic                  out_valid_q, out_valid_d;
  logic [AreaBits-1:0]   area_q;
  logic                  nonzero_q, aspect_ok_q, size_ok_q;
  logic [LoProdBits-1:0] lo_prod_q;
  logic [HiProdBits-1:0] hi_prod_q;
  logic                  aspect_ok, size_ok, area_ok;
  logic                  load_out;
  logic [AspectBits-1:0] w_ext, h_ext;

  assign w_ext = AspectBits'(q_data_i.width);
  assign h_ext = AspectBits'(q_data_i.height);

  assign aspect_ok = (w_ext * AspectWidthMul > h_ext * AspectHeightMul) &&
                     (w_ext < h_ext * AspectMaxRatio);
  assign size_ok   = (q_data_i.width > cfg_i.min_box_width) &&
                     (q_data_i.width < cfg_i.max_box_width) &&
                     (q_data_i.height > cfg_i.min_box_height) &&
                     (q_data_i.height < cfg_i.max_box_height);
  assign area_ok   = nonzero_q &&
                     (LoProdBits'(cfg_i.frame_area) >= lo_prod_q) &&
                     (HiProdBits'(cfg_i.frame_area) < hi_prod_q);

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    load_out    = 1'b0;
    verdict_d   = VERDICT_REJECT;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          state_d = BK_AREA;
        end
      end
      BK_AREA: begin
        state_d = BK_JUDGE;
      end
      BK_JUDGE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    priority if (!area_ok) begin
      verdict_d = VERDICT_REJECT;
    end else if (!aspect_ok_q) begin
      verdict_d = VERDICT_AREA_OK;
    end else if (!size_ok_q) begin
      verdict_d = VERDICT_ASPECT_OK;
    end else begin
      verdict_d = VERDICT_ALL_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      box_q       <= q_data_i;
      area_q      <= AreaBits'(q_data_i.width) * AreaBits'(q_data_i.height);
      aspect_ok_q <= aspect_ok;
      size_ok_q   <= size_ok;
    end
    if (state_q == BK_AREA) begin
      nonzero_q <= (area_q != '0);
      lo_prod_q <= (LoProdBits'(cfg_i.area_ratio_low) + LoProdBits'(1)) * LoProdBits'(area_q);
      hi_prod_q <= HiProdBits'(cfg_i.area_ratio_high) * HiProdBits'(area_q);
    end
    if (load_out) begin
      out_box_q <= box_q;
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign box_left_o   = out_box_q.left;
  assign box_top_o    = out_box_q.top;
  assign box_width_o  = out_box_q.width;
  assign box_height_o = out_box_q.height;
  assign verdict_o    = verdict_q;

  `CBPC_ASSERT_IMP(a_pass_nonzero, out_valid_o && verdict_q != VERDICT_REJECT,
                   box_width_o != '0 && box_height_o != '0, "passing box with zero area")
  `CBPC_ASSERT_IMP(a_pass_size, out_valid_o && verdict_q == VERDICT_ALL_OK,
                   box_width_o > cfg_i.min_box_width && box_width_o < cfg_i.max_box_width,
                   "passing box outside width bounds")
  `CBPC_ASSERT_NXT(a_pop_to_area, pop_o, state_q == BK_AREA, "judge unit lost a popped box")

endmodule

// File: hdl/contour_box_plate_classifier.sv
// top level of the contour box plate classifier: config registers and front/back
//
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    point_x_i, point_y_i, last_point_i
// out      output     out_valid_o / out_stall_i  box_left/top/width/height_o, verdict_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// points are taken one per cycle while the four-entry box queue has room
// the judge unit takes one box at a time: box area, area-ratio products, verdict
// a contour's box goes from the queue to the judge unit, then the output register
// out_stall_i holds the output register; the queue keeps the point side running meanwhile
// reset clears the tracker, the queue, the judge state and loads the default configuration
module contour_box_plate_classifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [cbpc_pkg::CoordBits-1:0]   point_x_i,
  input  logic [cbpc_pkg::CoordBits-1:0]   point_y_i,
  input  logic                             last_point_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cbpc_pkg::CoordBits-1:0]   box_left_o,
  output logic [cbpc_pkg::CoordBits-1:0]   box_top_o,
  output logic [cbpc_pkg::CoordBits-1:0]   box_width_o,
  output logic [cbpc_pkg::CoordBits-1:0]   box_height_o,
  output logic [1:0]                       verdict_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cbpc_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [cbpc_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import cbpc_pkg::*;

  cfg_t      cfg_q;
  q_status_t q_status;
  box_t      push_box, head_box;
  logic      push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_area      <= FrameAreaReset;
      cfg_q.area_ratio_low  <= AreaRatioLowReset;
      cfg_q.area_ratio_high <= AreaRatioHighReset;
      cfg_q.min_box_width   <= MinBoxWidthReset;
      cfg_q.max_box_width   <= MaxBoxWidthReset;
      cfg_q.min_box_height  <= MinBoxHeightReset;
      cfg_q.max_box_height  <= MaxBoxHeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_AREA:      cfg_q.frame_area      <= cfg_data_i[FrameBits-1:0];
        CFG_AREA_RATIO_LOW:  cfg_q.area_ratio_low  <= cfg_data_i[RatioBits-1:0];
        CFG_AREA_RATIO_HIGH: cfg_q.area_ratio_high <= cfg_data_i[RatioBits-1:0];
        CFG_MIN_BOX_WIDTH:   cfg_q.min_box_width   <= cfg_data_i[CoordBits-1:0];
        CFG_MAX_BOX_WIDTH:   cfg_q.max_box_width   <= cfg_data_i[CoordBits-1:0];
        CFG_MIN_BOX_HEIGHT:  cfg_q.min_box_height  <= cfg_data_i[CoordBits-1:0];
        CFG_MAX_BOX_HEIGHT:  cfg_q.max_box_height  <= cfg_data_i[CoordBits-1:0];
        default: begin
        end
      endcase
    end
  end

  cbpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .box_o        (push_box)
  );

  cbpc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_box),
    .pop_i    (pop),
    .data_o   (head_box),
    .status_o (q_status)
  );

  cbpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_status_i   (q_status),
    .q_data_i     (head_box),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .verdict_o    (verdict_o)
  );

endmodule

// File: test/contour_box_plate_classifier_tb.sv
// testbench for the contour box plate classifier: directed and random contours checked by a scoreboard
module contour_box_plate_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpc_pkg::*;

  localparam int ClkPeriod = 4;
  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 16;
  localparam int PointsPerPhase = 240;
  localparam int NumPhases = 6;
  localparam int NumRegs = 7;
  localparam int MaxReported = 10;
  localparam int CoordMax = 2 ** CoordBits - 1;
  localparam logic [CfgIndexBits-1:0] CfgIndexUnused = '1;

  typedef struct packed {
    box_t     box;
    verdict_e verdict;
  } plate_result_t;

  class plate_box_scoreboard;
    cfg_t regs;
    logic [CoordBits-1:0] x_min, x_max, y_min, y_max;
    bit new_contour;
    plate_result_t pending_boxes[$];
    int mismatch_count;

    function new();
      regs = '{FrameAreaReset, AreaRatioLowReset, AreaRatioHighReset, MinBoxWidthReset,
               MaxBoxWidthReset, MinBoxHeightReset, MaxBoxHeightReset};
      x_min = '0;
      x_max = '0;
      y_min = '0;
      y_max = '0;
      new_contour = 1'b1;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CFG_FRAME_AREA:      regs.frame_area = data[FrameBits-1:0];
        CFG_AREA_RATIO_LOW:  regs.area_ratio_low = data[RatioBits-1:0];
        CFG_AREA_RATIO_HIGH: regs.area_ratio_high = data[RatioBits-1:0];
        CFG_MIN_BOX_WIDTH:   regs.min_box_width = data[CoordBits-1:0];
        CFG_MAX_BOX_WIDTH:   regs.max_box_width = data[CoordBits-1:0];
        CFG_MIN_BOX_HEIGHT:  regs.min_box_height = data[CoordBits-1:0];
        CFG_MAX_BOX_HEIGHT:  regs.max_box_height = data[CoordBits-1:0];
        default: ;
      endcase
    endfunction

    function verdict_e grade_box(logic [CoordBits-1:0] w, logic [CoordBits-1:0] h);
      longint unsigned area, lo_bound, hi_bound, frame;
      area = 64'(w) * 64'(h);
      lo_bound = (64'(regs.area_ratio_low) + 64'd1) * area;
      hi_bound = 64'(regs.area_ratio_high) * area;
      frame = 64'(regs.frame_area);
      if (area == 0) return VERDICT_REJECT;
      if (!(frame >= lo_bound && frame < hi_bound)) return VERDICT_REJECT;
      if (!(64'(AspectWidthMul) * 64'(w) > 64'(AspectHeightMul) * 64'(h) &&
            64'(w) < 64'(AspectMaxRatio) * 64'(h))) return VERDICT_AREA_OK;
      if (!(w > regs.min_box_width && w < regs.max_box_width &&
            h > regs.min_box_height && h < regs.max_box_height)) return VERDICT_ASPECT_OK;
      return VERDICT_ALL_OK;
    endfunction

    function void note_point(logic [CoordBits-1:0] x, logic [CoordBits-1:0] y, logic last);
      plate_result_t want;
      if (new_contour) begin
        x_min = x;
        x_max = x;
        y_min = y;
        y_max = y;
      end else begin
        if (x < x_min) x_min = x;
        if (x > x_max) x_max = x;
        if (y < y_min) y_min = y;
        if (y > y_max) y_max = y;
      end
      new_contour = last;
      if (last) begin
        want.box.left = x_min;
        want.box.top = y_min;
        want.box.width = x_max - x_min;
        want.box.height = y_max - y_min;
        want.verdict = grade_box(want.box.width, want.box.height);
        pending_boxes.push_back(want);
      end
    endfunction

    function void check_box(plate_result_t got);
      plate_result_t want;
      if (pending_boxes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("unexpected transaction: left %0d top %0d width %0d height %0d verdict %0d",
                   got.box.left, got.box.top, got.box.width, got.box.height, got.verdict);
        return;
      end
      want = pending_boxes.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display({"box mismatch: expected left %0d top %0d width %0d height %0d verdict %0d,",
                    " actual left %0d top %0d width %0d height %0d verdict %0d"},
                   want.box.left, want.box.top, want.box.width, want.box.height, want.verdict,
                   got.box.left, got.box.top, got.box.width, got.box.height, got.verdict);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CoordBits-1:0] point_x_i = '0;
  logic [CoordBits-1:0] point_y_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CoordBits-1:0] box_left_o, box_top_o, box_width_o, box_height_o;
  logic [1:0] verdict_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  plate_box_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int points_sent = 0;
  int quiet_cycles = 0;
  logic any_transaction;

  contour_box_plate_classifier u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .point_x_i, .point_y_i, .last_point_i,
    .out_valid_o, .out_stall_i, .box_left_o, .box_top_o, .box_width_o, .box_height_o,
    .verdict_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_box('{box: '{box_left_o, box_top_o, box_width_o, box_height_o},
                     verdict: verdict_e'(verdict_o)});
  end

  assign any_transaction = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                           (cfg_valid_i && cfg_ready_o);

  always @(posedge clk_i) begin
    if (!rst_ni || any_transaction) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_point(input logic [CoordBits-1:0] x, input logic [CoordBits-1:0] y,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_point(x, y, last);
    points_sent++;
  endtask

  function automatic logic [CoordBits-1:0] pick_coord(logic [CoordBits-1:0] base,
                                                      logic [CoordBits-1:0] span);
    case ($urandom_range(3))
      0: return base;
      1: return base + span;
      default: return base + CoordBits'($urandom_range(span));
    endcase
  endfunction

  task automatic random_contour();
    logic [CoordBits-1:0] w, h, tmp;
    int count;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        w = CoordBits'($urandom_range(300, 40));
        h = CoordBits'($urandom_range(120, 5));
      end
      6, 7: begin
        w = CoordBits'($urandom_range(CoordMax));
        h = CoordBits'($urandom_range(CoordMax));
      end
      8: begin
        w = CoordBits'($urandom_range(CoordMax));
        h = '0;
        if ($urandom_range(1)) begin
          tmp = w;
          w = h;
          h = tmp;
        end
      end
      default: begin
        w = CoordBits'(CoordMax - $urandom_range(20));
        h = CoordBits'($urandom_range(CoordMax));
      end
    endcase
    count = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    tmp = CoordBits'($urandom_range(CoordMax - int'(w)));
    w = w;
    for (int i = 0; i < count; i++) begin
      send_point(pick_coord(tmp, w), pick_coord(CoordBits'(0), h) + CoordBits'(0), i == count - 1);
    end
  endtask

  task automatic cfg_write(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic load_config(input int setting);
    logic [CfgDataBits-1:0] vals [NumRegs];
    cfg_idx_e idx;
    case (setting)
      0: vals = '{CfgDataBits'($urandom_range(2000000, 50000)),
                  CfgDataBits'($urandom_range(40)), CfgDataBits'($urandom_range(1023, 100)),
                  CfgDataBits'($urandom_range(100)), CfgDataBits'($urandom_range(CoordMax, 150)),
                  CfgDataBits'($urandom_range(30)), CfgDataBits'($urandom_range(CoordMax, 60))};
      1: vals = '{default: '1};
      2: for (int i = 0; i < NumRegs; i++) vals[i] = CfgDataBits'($urandom);
      3: vals = '{default: '0};
      4: vals = '{CfgDataBits'(1 << 24), CfgDataBits'(0), CfgDataBits'(1023), CfgDataBits'(0),
                  CfgDataBits'(CoordMax), CfgDataBits'(0), CfgDataBits'(CoordMax)};
      default: vals = '{CfgDataBits'(FrameAreaReset), CfgDataBits'(AreaRatioLowReset),
                        CfgDataBits'(AreaRatioHighReset), CfgDataBits'(MinBoxWidthReset),
                        CfgDataBits'(MaxBoxWidthReset), CfgDataBits'(MinBoxHeightReset),
                        CfgDataBits'(MaxBoxHeightReset)};
    endcase
    idx = idx.first();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_write(idx, vals[i]);
      idx = idx.next();
    end
    cfg_write(CfgIndexUnused, CfgDataBits'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_boxes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int phase);
    case (phase / 2)
      0: begin
        send_idle_pct = 21;
        stall_pct = 50;
      end
      1: begin
        send_idle_pct = 50;
        stall_pct = 21;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);

    // single-point contours
    send_point('0, '0, 1'b1);
    send_point(CoordBits'(CoordMax), CoordBits'(CoordMax), 1'b1);
    // full-frame box
    send_point('0, '0, 1'b0);
    send_point(CoordBits'(CoordMax), CoordBits'(CoordMax), 1'b1);
    // zero height and zero width
    send_point(CoordBits'(100), CoordBits'(50), 1'b0);
    send_point(CoordBits'(300), CoordBits'(50), 1'b1);
    send_point(CoordBits'(70), CoordBits'(10), 1'b0);
    send_point(CoordBits'(70), CoordBits'(400), 1'b1);
    // plate that passes every test
    send_point(CoordBits'(275), CoordBits'(120), 1'b0);
    send_point(CoordBits'(200), CoordBits'(100), 1'b0);
    send_point(CoordBits'(350), CoordBits'(140), 1'b1);
    // area and aspect pass, size fails
    send_point(CoordBits'(10), CoordBits'(10), 1'b0);
    send_point(CoordBits'(88), CoordBits'(30), 1'b1);
    // square box fails aspect
    send_point(CoordBits'(560), CoordBits'(560), 1'b0);
    send_point(CoordBits'(530), CoordBits'(520), 1'b0);
    send_point(CoordBits'(500), CoordBits'(500), 1'b1);
    // x and y extremes in one contour
    send_point(CoordBits'(CoordMax), '0, 1'b0);
    send_point('0, CoordBits'(CoordMax), 1'b1);
    drain();

    for (int phase = 0; phase < NumPhases; phase++) begin
      set_idling(phase);
      load_config(phase);
      points_sent = 0;
      while (points_sent < PointsPerPhase) random_contour();
      drain();
    end

    if (sb.mismatch_count == 0 && sb.pending_boxes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/cbpc_pkg.sv
hdl/cbpc_front.sv
hdl/cbpc_queue.sv
hdl/cbpc_back.sv
hdl/contour_box_plate_classifier.sv
test/contour_box_plate_classifier_tb.sv
